>>> rtl/keyword_bold_span_marker_macros.svh
// Assertion macros for the keyword bold span marker.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef KEYWORD_BOLD_SPAN_MARKER_MACROS_SVH
`define KEYWORD_BOLD_SPAN_MARKER_MACROS_SVH
// Assert an implication, disabled while in reset.
`define KBSM_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assert that a condition never holds, disabled while in reset.
`define KBSM_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

>>> rtl/kbsm_pkg.sv
// Shared types and constants for the keyword bold span marker.
// No dependencies.
package kbsm_pkg;
  typedef enum logic [1:0] {
    REQ_CHAR = 2'd0,
    REQ_LEN  = 2'd1,
    REQ_TEXT = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_WAIT
  } state_e;
endpackage

>>> rtl/kbsm_dict.sv
// Dictionary store: character memory (one read port, registered) and word lengths.
// No dependencies.
module kbsm_dict #(
  parameter int MAX_WORDS    = 16,
  parameter int MAX_WORD_LEN = 16,
  parameter int SW           = 4,
  parameter int PW           = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cwr_i,
  input  logic [SW-1:0] cwr_slot_i,
  input  logic [PW-1:0] cwr_pos_i,
  input  logic [7:0]    cwr_data_i,
  input  logic          lwr_i,
  input  logic [SW-1:0] lwr_slot_i,
  input  logic [4:0]    lwr_len_i,
  input  logic [SW-1:0] rd_slot_i,
  input  logic [PW-1:0] rd_pos_i,
  output logic [7:0]    rd_char_o,
  output logic [4:0]    rd_len_o
);
  localparam int AW = (MAX_WORDS * MAX_WORD_LEN > 1) ? $clog2(MAX_WORDS * MAX_WORD_LEN) : 1;

  logic [7:0] chars_mem [MAX_WORDS*MAX_WORD_LEN];
  logic [4:0] len_q [MAX_WORDS];
  logic [AW-1:0] waddr, raddr;

  assign waddr = AW'(cwr_slot_i) * AW'(MAX_WORD_LEN) + AW'(cwr_pos_i);
  assign raddr = AW'(rd_slot_i) * AW'(MAX_WORD_LEN) + AW'(rd_pos_i);

  always_ff @(posedge clk_i) begin
    if (cwr_i) begin
      chars_mem[waddr] <= cwr_data_i;
    end
    rd_char_o <= chars_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WORDS; i++) len_q[i] <= '0;
    end else if (lwr_i) begin
      len_q[lwr_slot_i] <= lwr_len_i;
    end
  end

  assign rd_len_o = len_q[rd_slot_i];
endmodule

>>> rtl/keyword_bold_span_marker.sv
// Keyword bold span marker. Load items write the dictionary when accepted. A text byte that
// fills the window, and each byte flushed at text end, is resolved by walking the
// dictionary one slot at a time and comparing one character per cycle from the
// character memory; only slots below min(word_count, MAX_WORDS) are searched, only
// slots whose word fits in the window are compared, and a mismatch ends that slot
// early. The input is stalled from the accept of that byte until it is emitted.
// The result sits in an output register; a byte whose search
// ends while that register is still held waits, and stalls the input, until it drains.
// Depends on kbsm_pkg, kbsm_dict and keyword_bold_span_marker_macros.svh.
`include "keyword_bold_span_marker_macros.svh"
module keyword_bold_span_marker #(
  parameter int MAX_WORDS    = 16,
  parameter int MAX_WORD_LEN = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] slot_i,
  input  logic [3:0] char_pos_i,
  input  logic [4:0] length_i,
  input  logic [7:0] char_value_i,
  input  logic       text_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       open_before_o,
  output logic       close_before_o,
  output logic       close_after_o,
  output logic       last_out_o
);
  localparam int SW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int FW = $clog2(MAX_WORD_LEN + 1);
  localparam int CW = $clog2(MAX_WORDS + 1);

  kbsm_pkg::state_e state_q, state_d;
  logic [4:0]    wcount_q;
  logic [7:0]    win_q [MAX_WORD_LEN];
  logic [FW-1:0] fill_q, fill_d;
  logic [4:0]    cov_q, cov_d;
  logic          prev_q, prev_d, flush_q, flush_d;
  logic [CW-1:0] sidx_q, sidx_d;
  logic [PW:0]   kidx_q, kidx_d;
  logic [4:0]    len_q, len_d;
  logic          ovalid_q, ovalid_d;
  logic [7:0]    obyte_q;
  logic          oopen_q, oclose_q, oafter_q, olast_q;
  logic          emit;
  logic          bold;

  logic          acc;
  logic [SW-1:0] rd_slot;
  logic [PW-1:0] rd_pos;
  logic [7:0]    rd_char;
  logic [4:0]    rd_len;
  logic [CW-1:0] nwords;
  logic          len_ok;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != kbsm_pkg::ST_IDLE);
  assign nwords = (32'(wcount_q) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(wcount_q);
  assign rd_slot = sidx_q[SW-1:0];
  assign rd_pos = kidx_q[PW-1:0];

  kbsm_dict #(.MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN), .SW(SW), .PW(PW))
    u_dict (
    .clk_i, .rst_ni,
    .cwr_i(acc && req_type_i == kbsm_pkg::REQ_CHAR && 32'(slot_i) < MAX_WORDS
           && 32'(char_pos_i) < MAX_WORD_LEN),
    .cwr_slot_i(SW'(slot_i)), .cwr_pos_i(PW'(char_pos_i)), .cwr_data_i(char_value_i),
    .lwr_i(acc && req_type_i == kbsm_pkg::REQ_LEN && 32'(slot_i) < MAX_WORDS),
    .lwr_slot_i(SW'(slot_i)), .lwr_len_i(length_i),
    .rd_slot_i(rd_slot), .rd_pos_i(rd_pos), .rd_char_o(rd_char), .rd_len_o(rd_len)
  );

  assign len_ok = (rd_len != 5'd0) && (32'(rd_len) <= 32'(fill_q));
  assign bold = (cov_q != 5'd0);

  always_comb begin
    state_d = state_q; fill_d = fill_q; cov_d = cov_q; prev_d = prev_q;
    flush_d = flush_q; sidx_d = sidx_q; kidx_d = kidx_q; len_d = len_q;
    ovalid_d = ovalid_q && out_stall_i;
    emit = 1'b0;
    unique case (state_q)
      kbsm_pkg::ST_IDLE: begin
        if (acc && req_type_i == kbsm_pkg::REQ_TEXT) begin
          if (32'(fill_q) < MAX_WORD_LEN) fill_d = fill_q + 1'b1;
          flush_d = text_last_i;
          sidx_d = '0; kidx_d = '0;
          if (text_last_i || 32'(fill_q) + 1 >= MAX_WORD_LEN) state_d = kbsm_pkg::ST_SCAN;
        end
      end
      kbsm_pkg::ST_SCAN: begin
        kidx_d = '0;
        if (sidx_q >= nwords) begin
          state_d = kbsm_pkg::ST_WAIT;
        end else if (len_ok) begin
          len_d = rd_len;
          state_d = kbsm_pkg::ST_CMP;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      kbsm_pkg::ST_CMP: begin
        // memory data is registered, so it is for kidx_q-1 once kidx_q is nonzero; compare when valid
        if (kidx_q != '0 && rd_char != win_q[PW'(kidx_q - 1'b1)]) begin
          sidx_d = sidx_q + 1'b1; state_d = kbsm_pkg::ST_SCAN; kidx_d = '0;
        end else if (kidx_q == (PW+1)'(len_q)) begin
          if (len_q > cov_q) cov_d = len_q;
          sidx_d = sidx_q + 1'b1; state_d = kbsm_pkg::ST_SCAN; kidx_d = '0;
        end else begin
          kidx_d = kidx_q + 1'b1;
        end
      end
      kbsm_pkg::ST_WAIT: begin
        if (!ovalid_q || !out_stall_i) begin
          emit = 1'b1; ovalid_d = 1'b1;
          prev_d = bold;
          cov_d = bold ? cov_q - 1'b1 : 5'd0;
          fill_d = fill_q - 1'b1;
          sidx_d = '0; kidx_d = '0;
          if (flush_q && fill_q > FW'(1)) begin
            state_d = kbsm_pkg::ST_SCAN;
          end else begin
            state_d = kbsm_pkg::ST_IDLE;
            if (flush_q) begin cov_d = '0; prev_d = 1'b0; end
          end
        end
      end
      default: state_d = kbsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbsm_pkg::ST_IDLE; wcount_q <= '0; fill_q <= '0; cov_q <= '0;
      prev_q <= 1'b0; flush_q <= 1'b0; sidx_q <= '0; kidx_q <= '0; len_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; cov_q <= cov_d; prev_q <= prev_d;
      flush_q <= flush_d; sidx_q <= sidx_d; kidx_q <= kidx_d; len_q <= len_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) wcount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == kbsm_pkg::ST_IDLE && acc && req_type_i == kbsm_pkg::REQ_TEXT
        && 32'(fill_q) < MAX_WORD_LEN) begin
      win_q[PW'(fill_q)] <= char_value_i;
    end
    if (emit) begin
      obyte_q  <= win_q[0];
      oopen_q  <= bold && !prev_q;
      oclose_q <= !bold && prev_q;
      olast_q  <= flush_q && fill_q == FW'(1);
      oafter_q <= flush_q && fill_q == FW'(1) && bold;
      // advance the window by one byte
      for (int i = 0; i < MAX_WORD_LEN - 1; i++) win_q[i] <= win_q[i+1];
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_byte_o = obyte_q;
  assign open_before_o = oopen_q;
  assign close_before_o = oclose_q;
  assign close_after_o = oafter_q;
  assign last_out_o = olast_q;

  `KBSM_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != kbsm_pkg::ST_IDLE) |-> in_stall_o, "request accepted while busy")
  `KBSM_ASSERT(a_fill_range, clk_i, rst_ni, 32'(fill_q) <= MAX_WORD_LEN, "window overfill")
  `KBSM_ASSERT(a_emit_nonempty, clk_i, rst_ni, emit |-> (fill_q != '0), "emit from empty window")
  `KBSM_NEVER(a_open_close, clk_i, rst_ni, out_valid_o && open_before_o && close_before_o, "open and close together")
endmodule
